[sv/raptor_triple_index_generator_top_defines.svh]
// assertion macros for the raptor triple index generator
`ifndef RAPTOR_TRIPLE_INDEX_GENERATOR_TOP_DEFINES_SVH
`define RAPTOR_TRIPLE_INDEX_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define RTIG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtig: same-cycle check failed");
// antecedent implies consequent in the next cycle
`define RTIG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtig: next-cycle check failed");
`else
`define RTIG_ASSERT_SAME(label, ante, cons)
`define RTIG_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[sv/rtig_pkg.sv]
// shared constants, types and the degree lookup of the triple generator
package rtig_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int WORD_W      = 32;

  // field widths
  localparam int SYM_W = 16;
  localparam int IDX_W = 14;
  localparam int DEG_W = 6;
  localparam int SEL_W = 2;

  // arithmetic constants
  localparam logic [16:0] PRIME_Q  = 17'd65521;
  localparam logic [26:0] CA_BASE  = 27'd53591;
  localparam logic [26:0] CA_MULT  = 27'd997;
  localparam logic [30:0] CB_MULT  = 31'd10267;

  // serial modulo unit widths
  localparam int MOD_DVD_W = 33;
  localparam int MOD_M_W   = 17;

  // opcodes
  localparam logic [1:0] OP_GEN         = 2'd0;
  localparam logic [1:0] OP_LOAD_FIRST  = 2'd1;
  localparam logic [1:0] OP_LOAD_SECOND = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SYSTEMATIC = 2'd0;
  localparam logic [1:0] CFG_INTER_CNT  = 2'd1;
  localparam logic [1:0] CFG_PRIME_CNT  = 2'd2;

  // table read selectors
  localparam logic [SEL_W-1:0] SEL_DEGREE = 2'd0;
  localparam logic [SEL_W-1:0] SEL_STEP   = 2'd1;

  // request to the modulo unit
  typedef struct packed {
    logic                 start;
    logic [MOD_DVD_W-1:0] dividend;
    logic [MOD_M_W-1:0]   modulus;
  } mod_req_t;

  // answer of the modulo unit
  typedef struct packed {
    logic               done;
    logic [MOD_M_W-1:0] remainder;
  } mod_rsp_t;

  // degree from a 20-bit random value
  function automatic logic [DEG_W-1:0] degree_of(input logic [19:0] v);
    logic [DEG_W-1:0] d;
    if (v < 20'd10241)        d = 6'd1;
    else if (v < 20'd491582)  d = 6'd2;
    else if (v < 20'd712794)  d = 6'd3;
    else if (v < 20'd831695)  d = 6'd4;
    else if (v < 20'd948446)  d = 6'd10;
    else if (v < 20'd1032189) d = 6'd11;
    else                      d = 6'd40;
    return d;
  endfunction

endpackage

[sv/rtig_serial_mod.sv]
// bit-serial restoring modulo unit, one dividend bit per cycle
module rtig_serial_mod
  import rtig_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  localparam int CNT_W = $clog2(MOD_DVD_W + 1);

  logic [MOD_DVD_W-1:0] dvd_r;
  logic [MOD_M_W-1:0]   mod_r;
  logic [MOD_M_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [MOD_M_W:0]     trial;
  logic                 ge;

  // shift in the next dividend bit and conditionally subtract
  always_comb begin
    trial   = {rem_r, dvd_r[MOD_DVD_W-1]};
    ge      = trial >= {1'b0, mod_r};
    rem_nxt = ge ? MOD_M_W'(trial - {1'b0, mod_r}) : trial[MOD_M_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(MOD_DVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      mod_r <= req.modulus;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[MOD_DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  // a zero modulus reduces to zero
  assign rsp.done      = done_r;
  assign rsp.remainder = (mod_r == '0) ? '0 : rem_r;

endmodule

[sv/raptor_triple_index_generator_top.sv]
// top level of the raptor triple index generator
// usage:
//   in_*  : requests; in_tuser is the opcode (generate, load first table,
//           load second table). A load writes one table word and gives no
//           result. A generate request returns degree results.
//   out_* : one result per intermediate symbol index, out_tlast on the final
//           index of a run.
//   cfg_* : register writes (systematic index, L, L prime), always ready;
//           write them only while the block is idle.
//   work: a generate request runs five reductions, one after another, on
//           one bit-serial modulo unit; each index of the run is then found
//           by stepping past skipped values (at most L prime per skip run).
//   one request is in work at a time; in_tready is high only when idle.
//   a stalled receiver holds the current result; the run waits with it.
//   reset (rst_n, synchronous) clears the control state and the configuration
//   registers to reset values; table contents stay undefined until loaded.
`include "raptor_triple_index_generator_top_defines.svh"
module raptor_triple_index_generator_top
  import rtig_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // table_index[7:0], table_word[39:8], symbol_id[55:40]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // symbol_index[13:0], degree[19:14], position[25:20], zeros
  output logic        out_tlast,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_CA   = 12'b000000000010,
    S_CB   = 12'b000000000100,
    S_MUL  = 12'b000000001000,
    S_YL   = 12'b000000010000,
    S_Y    = 12'b000000100000,
    S_RD   = 12'b000001000000,
    S_USE  = 12'b000010000000,
    S_MA   = 12'b000100000000,
    S_MB   = 12'b001000000000,
    S_SKIP = 12'b010000000000,
    S_EMIT = 12'b100000000000
  } state_t;

  // request fields
  logic [1:0]        in_opcode;
  logic [TBL_AW-1:0] in_table_index;
  logic [WORD_W-1:0] in_table_word;
  logic [SYM_W-1:0]  in_symbol_id;
  logic              in_acc, out_acc;

  assign in_opcode      = in_tuser;
  assign in_table_index = in_tdata[7:0];
  assign in_table_word  = in_tdata[39:8];
  assign in_symbol_id   = in_tdata[55:40];
  assign in_acc         = in_tvalid && in_tready;
  assign out_acc        = out_tvalid && out_tready;

  // configuration registers
  logic [15:0]      sys_r;
  logic [IDX_W-1:0] l_r, lp_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sys_r <= '0;
      l_r   <= IDX_W'(4);
      lp_r  <= IDX_W'(5);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SYSTEMATIC: sys_r <= cfg_data;
        CFG_INTER_CNT:  l_r   <= cfg_data[IDX_W-1:0];
        CFG_PRIME_CNT:  lp_r  <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and working registers
  state_t            state_r, state_nxt;
  logic [SYM_W-1:0]  x_r, x_nxt;
  logic [15:0]       ca_r, ca_nxt, cb_r, cb_nxt, y_r, y_nxt;
  logic [31:0]       prod_r, prod_nxt;
  logic [SEL_W-1:0]  sel_r, sel_nxt;
  logic [DEG_W-1:0]  deg_r, deg_nxt, pos_r, pos_nxt;
  logic [IDX_W-1:0]  a_r, a_nxt, b_r, b_nxt, n_r, n_nxt;

  // table memories
  logic [WORD_W-1:0] t0_mem [TABLE_DEPTH];
  logic [WORD_W-1:0] t1_mem [TABLE_DEPTH];
  logic [WORD_W-1:0] t0_q_r, t1_q_r;
  logic [TBL_AW-1:0] lo_addr, hi_addr;

  assign lo_addr = y_r[7:0]  + TBL_AW'(sel_r);
  assign hi_addr = y_r[15:8] + TBL_AW'(sel_r);

  always_ff @(posedge clk) begin
    if (in_acc && in_opcode == OP_LOAD_FIRST) begin
      t0_mem[in_table_index] <= in_table_word;
    end
    t0_q_r <= t0_mem[lo_addr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_opcode == OP_LOAD_SECOND) begin
      t1_mem[in_table_index] <= in_table_word;
    end
    t1_q_r <= t1_mem[hi_addr];
  end

  // shared modulo unit
  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  rtig_serial_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  // operands
  logic [26:0]       ca_arg;
  logic [30:0]       cb_arg;
  logic [IDX_W-1:0]  pm1;
  logic [WORD_W-1:0] word;
  logic [IDX_W:0]    step_sum;
  logic [IDX_W-1:0]  b_step;
  logic              skip_more;

  assign ca_arg   = CA_BASE + 27'(27'(sys_r) * CA_MULT);
  assign cb_arg   = CB_MULT * (31'(sys_r) + 31'd1);
  assign pm1      = (lp_r == '0) ? '0 : lp_r - 1'b1;
  assign word     = t0_q_r ^ t1_q_r;
  assign step_sum = {1'b0, b_r} + {1'b0, a_r};

  // next index modulo L prime, one compare and subtract
  always_comb begin
    if (lp_r == '0) begin
      b_step = '0;
    end else if (step_sum >= {1'b0, lp_r}) begin
      b_step = IDX_W'(step_sum - {1'b0, lp_r});
    end else begin
      b_step = step_sum[IDX_W-1:0];
    end
  end

  assign skip_more = (b_r >= l_r) && (n_r < lp_r);

  // next-state logic
  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    ca_nxt    = ca_r;
    cb_nxt    = cb_r;
    y_nxt     = y_r;
    prod_nxt  = prod_r;
    sel_nxt   = sel_r;
    deg_nxt   = deg_r;
    pos_nxt   = pos_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    n_nxt     = n_r;
    mod_req   = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_opcode == OP_GEN) begin
          x_nxt            = in_symbol_id;
          mod_req.start    = 1'b1;
          mod_req.dividend = MOD_DVD_W'(ca_arg);
          mod_req.modulus  = PRIME_Q;
          state_nxt        = S_CA;
        end
      end
      S_CA: begin
        if (mod_rsp.done) begin
          ca_nxt           = mod_rsp.remainder[15:0];
          mod_req.start    = 1'b1;
          mod_req.dividend = MOD_DVD_W'(cb_arg);
          mod_req.modulus  = PRIME_Q;
          state_nxt        = S_CB;
        end
      end
      S_CB: begin
        if (mod_rsp.done) begin
          cb_nxt    = mod_rsp.remainder[15:0];
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = 32'(x_r) * 32'(ca_r);
        state_nxt = S_YL;
      end
      S_YL: begin
        mod_req.start    = 1'b1;
        mod_req.dividend = MOD_DVD_W'(cb_r) + MOD_DVD_W'(prod_r);
        mod_req.modulus  = PRIME_Q;
        state_nxt        = S_Y;
      end
      S_Y: begin
        if (mod_rsp.done) begin
          y_nxt     = mod_rsp.remainder[15:0];
          sel_nxt   = SEL_DEGREE;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_USE;
      end
      S_USE: begin
        case (sel_r)
          SEL_DEGREE: begin
            deg_nxt   = degree_of(word[19:0]);
            sel_nxt   = SEL_STEP;
            state_nxt = S_RD;
          end
          SEL_STEP: begin
            mod_req.start    = 1'b1;
            mod_req.dividend = MOD_DVD_W'(word);
            mod_req.modulus  = MOD_M_W'(pm1);
            state_nxt        = S_MA;
          end
          default: begin
            mod_req.start    = 1'b1;
            mod_req.dividend = MOD_DVD_W'(word);
            mod_req.modulus  = MOD_M_W'(lp_r);
            state_nxt        = S_MB;
          end
        endcase
      end
      S_MA: begin
        if (mod_rsp.done) begin
          a_nxt     = mod_rsp.remainder[IDX_W-1:0] + 1'b1;
          sel_nxt   = sel_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_MB: begin
        if (mod_rsp.done) begin
          b_nxt     = mod_rsp.remainder[IDX_W-1:0];
          n_nxt     = '0;
          pos_nxt   = '0;
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        // step past indices at or above L, bounded by L prime steps
        if (skip_more) begin
          b_nxt = b_step;
          n_nxt = n_r + 1'b1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_acc) begin
          if (out_tlast) begin
            state_nxt = S_IDLE;
          end else begin
            b_nxt     = b_step;
            n_nxt     = '0;
            pos_nxt   = pos_r + 1'b1;
            state_nxt = S_SKIP;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    ca_r   <= ca_nxt;
    cb_r   <= cb_nxt;
    y_r    <= y_nxt;
    prod_r <= prod_nxt;
    sel_r  <= sel_nxt;
    deg_r  <= deg_nxt;
    pos_r  <= pos_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    n_r    <= n_nxt;
  end

  // ports
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_EMIT);
  assign out_tdata  = {6'b0, pos_r, deg_r, b_r};
  assign out_tlast  = ((pos_r + 1'b1) == deg_r);

  // checks
  `RTIG_ASSERT_SAME(a_pos_below_degree, out_tvalid, pos_r < deg_r)
  `RTIG_ASSERT_NEXT(a_last_ends_run, out_acc && out_tlast, state_r == S_IDLE)
  `RTIG_ASSERT_SAME(a_mod_done_awaited, mod_rsp.done,
                    state_r == S_CA || state_r == S_CB || state_r == S_Y ||
                    state_r == S_MA || state_r == S_MB)

endmodule

[dv/raptor_triple_index_generator_top_tb.sv]
// self-checking testbench for the raptor triple index generator top level
`timescale 1ns / 100ps

module raptor_triple_index_generator_top_tb;
  import rtig_pkg::*;

  // opcode that the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned STALL_LIMIT       = 100000;
  localparam int unsigned LONG_HOLD         = 600;
  localparam int unsigned SETTLE_CYCLES     = 20;
  localparam int unsigned TAIL_CYCLES       = 300;
  localparam int unsigned ITEMS_PER_SETTING = 36;
  localparam int          NUM_SETTINGS      = 8;
  localparam int          NUM_DIRECTED      = 26;

  // one emitted intermediate symbol index
  typedef struct packed {
    logic [IDX_W-1:0] symbol_index;
    logic [DEG_W-1:0] degree;
    logic [DEG_W-1:0] position;
    logic             last;
  } index_result_t;

  // one row of the directed table; typed rows carry a single known result
  typedef struct packed {
    logic [1:0]        op;
    logic [TBL_AW-1:0] tindex;
    logic [WORD_W-1:0] word;
    logic [SYM_W-1:0]  sym;
    logic              typed;
    logic [IDX_W-1:0]  t_index;
    logic [DEG_W-1:0]  t_degree;
  } stim_row_t;

  // one register setting and how traffic behaves under it
  typedef struct packed {
    logic [15:0]      sys_index;
    logic [IDX_W-1:0] inter_count;
    logic [IDX_W-1:0] prime_count;
    logic             no_idle;
    logic             long_hold;
    logic             mid_pause;
  } setting_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [55:0]       in_tdata   = '0;
  logic [1:0]        in_tuser   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;
  logic              out_tlast;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index  = '0;
  logic [15:0]       cfg_data   = '0;

  // predictor state: table copies, registers and expected indices
  logic [WORD_W-1:0] first_words  [TABLE_DEPTH];
  logic [WORD_W-1:0] second_words [TABLE_DEPTH];
  bit                first_loaded  [TABLE_DEPTH];
  bit                second_loaded [TABLE_DEPTH];
  logic [15:0]       sys_index_q   = 16'd0;
  logic [IDX_W-1:0]  inter_count_q = 14'd4;
  logic [IDX_W-1:0]  prime_count_q = 14'd5;
  index_result_t     pending_indices [$];

  int unsigned mismatch_count  = 0;
  int unsigned items_sent      = 0;
  int unsigned gen_requests    = 0;
  int unsigned load_requests   = 0;
  int unsigned indices_checked = 0;
  int unsigned deg40_runs      = 0;
  int unsigned idle_cycles     = 0;
  bit [40:0]   degrees_seen    = '0;
  bit          no_idle         = 1'b0;
  bit          long_hold_req   = 1'b0;

  raptor_triple_index_generator_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Y = (B + X*A) mod 65521 for the current systematic index
  function automatic logic [16:0] code_point(input logic [SYM_W-1:0] sym);
    logic [63:0] ca, cb, y;
    ca = (64'd53591 + 64'(sys_index_q) * 64'd997) % 64'd65521;
    cb = (64'd10267 * (64'(sys_index_q) + 64'd1)) % 64'd65521;
    y  = (cb + 64'(sym) * ca) % 64'd65521;
    return y[16:0];
  endfunction

  // xor of the two table words picked by y and step, reduced by m (0 gives 0)
  function automatic logic [31:0] table_draw(input logic [16:0] y, input int unsigned step,
                                             input logic [31:0] m);
    logic [7:0]  lo, hi;
    logic [31:0] w;
    lo = 8'(y + 17'(step));
    hi = 8'((y >> 8) + 17'(step));
    w  = first_words[lo] ^ second_words[hi];
    return (m == 32'd0) ? 32'd0 : w % m;
  endfunction

  // published degree distribution on a 20-bit draw
  function automatic logic [DEG_W-1:0] degree_for_draw(input logic [31:0] v);
    if (v < 32'd10241)   return 6'd1;
    if (v < 32'd491582)  return 6'd2;
    if (v < 32'd712794)  return 6'd3;
    if (v < 32'd831695)  return 6'd4;
    if (v < 32'd948446)  return 6'd10;
    if (v < 32'd1032189) return 6'd11;
    return 6'd40;
  endfunction

  // step past indices at or above L, giving up after L' steps
  function automatic logic [31:0] skip_unused(input logic [31:0] b, input logic [31:0] a);
    logic [31:0] n;
    n = 32'd0;
    // the loop only runs while n < L', so L' is never zero here
    while (b >= inter_count_q && n < prime_count_q) begin
      b = (b + a) % prime_count_q;
      n++;
    end
    return b;
  endfunction

  // expected indices of one generate request
  function automatic void expand_triple(input logic [SYM_W-1:0] sym);
    logic [16:0]      y;
    logic [31:0]      a, b, pm1;
    logic [DEG_W-1:0] d;
    index_result_t    r;
    y   = code_point(sym);
    d   = degree_for_draw(table_draw(y, 0, 32'h0010_0000));
    pm1 = (prime_count_q == 0) ? 32'd0 : 32'(prime_count_q) - 32'd1;
    a   = 32'd1 + table_draw(y, 1, pm1);
    b   = skip_unused(table_draw(y, 2, 32'(prime_count_q)), a);
    for (int k = 0; k < int'(d); k++) begin
      if (k > 0) begin
        b = (prime_count_q == 0) ? 32'd0 : (b + a) % prime_count_q;
        b = skip_unused(b, a);
      end
      r.symbol_index = b[IDX_W-1:0];
      r.degree       = d;
      r.position     = k[DEG_W-1:0];
      r.last         = (k + 1 == int'(d));
      pending_indices.push_back(r);
    end
    degrees_seen[d] = 1'b1;
    if (d == 6'd40) deg40_runs++;
  endfunction

  // table writes and generate expansion for an accepted request
  function automatic void predict_request(input logic [1:0] op, input logic [7:0] tindex,
                                          input logic [31:0] word, input logic [15:0] sym);
    case (op)
      OP_LOAD_FIRST: begin
        first_words[tindex]  = word;
        first_loaded[tindex] = 1'b1;
      end
      OP_LOAD_SECOND: begin
        second_words[tindex]  = word;
        second_loaded[tindex] = 1'b1;
      end
      OP_GEN: expand_triple(sym);
      default: ;
    endcase
  endfunction

  // sender gap: mostly none, some short, a few long
  function automatic int unsigned sender_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stall: mostly none, some short, a few long
  function automatic int unsigned receiver_stall();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // offer one request and wait for its handshake; valid stays high afterwards
  task automatic send_request(input logic [1:0] op, input logic [7:0] tindex,
                              input logic [31:0] word, input logic [15:0] sym);
    int unsigned gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {sym, word, tindex};
    do @(posedge clk); while (!in_tready);
    if (op != OP_UNUSED) items_sent++;
    if (op == OP_GEN) gen_requests++;
    if (op == OP_LOAD_FIRST || op == OP_LOAD_SECOND) load_requests++;
  endtask

  task automatic issue_request(input logic [1:0] op, input logic [7:0] tindex,
                               input logic [31:0] word, input logic [15:0] sym);
    send_request(op, tindex, word, sym);
    predict_request(op, tindex, word, sym);
  endtask

  // load every table entry that a generate of sym would read and is still unwritten
  task automatic ensure_tables(input logic [15:0] sym);
    logic [16:0] y;
    logic [7:0]  lo, hi;
    y = code_point(sym);
    for (int i = 0; i < 3; i++) begin
      lo = 8'(y + 17'(i));
      hi = 8'((y >> 8) + 17'(i));
      if (!first_loaded[lo])  issue_request(OP_LOAD_FIRST, lo, $urandom, 16'($urandom));
      if (!second_loaded[hi]) issue_request(OP_LOAD_SECOND, hi, $urandom, 16'($urandom));
    end
  endtask

  // wait until every expected index has come and the block is idle
  task automatic drain_results();
    do @(posedge clk); while (pending_indices.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // write all three registers back to back
  task automatic program_registers(input setting_t s);
    logic [1:0]  idxs [3];
    logic [15:0] vals [3];
    idxs = '{CFG_SYSTEMATIC, CFG_INTER_CNT, CFG_PRIME_CNT};
    vals = '{s.sys_index, 16'(s.inter_count), 16'(s.prime_count)};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (idxs[i])
        CFG_SYSTEMATIC: sys_index_q   = vals[i];
        CFG_INTER_CNT:  inter_count_q = vals[i][IDX_W-1:0];
        CFG_PRIME_CNT:  prime_count_q = vals[i][IDX_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // random mix: generates with their table loads, stray loads, ignored opcodes
  task automatic run_random(input int unsigned count, input bit long_hold,
                            input bit mid_pause);
    int unsigned goal, pick;
    logic [15:0] sym;
    bit          hold_done, pause_done;
    goal       = items_sent + count;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    while (items_sent < goal) begin
      // hold the receiver off while requests keep coming
      if (long_hold && !hold_done && items_sent + (count * 3) / 4 >= goal) begin
        long_hold_req = 1'b1;
        hold_done     = 1'b1;
      end
      // sender pause until the block has drained
      if (mid_pause && !pause_done && items_sent + count / 2 >= goal) begin
        in_tvalid <= 1'b0;
        drain_results();
        pause_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        sym = 16'($urandom);
        ensure_tables(sym);
        issue_request(OP_GEN, 8'($urandom), $urandom, sym);
      end else if (pick < 90) begin
        issue_request($urandom_range(0, 1) ? OP_LOAD_SECOND : OP_LOAD_FIRST,
                      8'($urandom), $urandom, 16'($urandom));
      end else begin
        issue_request(OP_UNUSED, 8'($urandom), $urandom, 16'($urandom));
      end
    end
  endtask

  // result side ready pattern, with one long hold on request
  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else if (stall == 0) begin
        stall = receiver_stall();
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // compare each accepted index with the oldest expectation
  always @(posedge clk) begin : result_check
    index_result_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[13:0], out_tdata[19:14], out_tdata[25:20], out_tlast};
      if (pending_indices.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected index %0d degree %0d position %0d last %0b", $time,
                 got.symbol_index, got.degree, got.position, got.last);
      end else begin
        want = pending_indices.pop_front();
        indices_checked++;
        if (got !== want) begin
          mismatch_count++;
          $display("%0t: expected index %0d degree %0d position %0d last %0b", $time,
                   want.symbol_index, want.degree, want.position, want.last);
          $display("%0t:   actual index %0d degree %0d position %0d last %0b", $time,
                   got.symbol_index, got.degree, got.position, got.last);
        end
      end
    end
  end

  // progress watchdog over all three channels
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t     directed_rows [NUM_DIRECTED];
    setting_t      settings [NUM_SETTINGS];
    index_result_t typed_result;

    // symbol 0 under the reset systematic index reads first[27..29], second[40..42]
    directed_rows = '{
      '{OP_LOAD_FIRST,  8'd27,  32'h0010_0000, 16'd0,      1'b0, 14'd0, 6'd0},
      '{OP_LOAD_SECOND, 8'd40,  32'd0,         16'd0,      1'b0, 14'd0, 6'd0},
      '{OP_LOAD_FIRST,  8'd28,  32'd0,         16'd0,      1'b0, 14'd0, 6'd0},
      '{OP_LOAD_SECOND, 8'd41,  32'd0,         16'd0,      1'b0, 14'd0, 6'd0},
      '{OP_LOAD_FIRST,  8'd29,  32'd0,         16'd0,      1'b0, 14'd0, 6'd0},
      '{OP_LOAD_SECOND, 8'd42,  32'd0,         16'd0,      1'b0, 14'd0, 6'd0},
      // draw wraps to zero: degree 1, step 1, start 0
      '{OP_GEN,         8'd0,   32'd0,         16'd0,      1'b1, 14'd0, 6'd1},
      // ignored opcode must leave the tables alone
      '{OP_UNUSED,      8'd255, 32'hFFFF_FFFF, 16'hFFFF,   1'b0, 14'd0, 6'd0},
      '{OP_GEN,         8'd255, 32'hFFFF_FFFF, 16'd0,      1'b1, 14'd0, 6'd1},
      // degree thresholds: each side of the first one, then the next three exactly
      '{OP_LOAD_FIRST,  8'd27,  32'd10240,     16'd0,      1'b0, 14'd0, 6'd0},
      '{OP_GEN,         8'd0,   32'd0,         16'd0,      1'b1, 14'd0, 6'd1},
      '{OP_LOAD_FIRST,  8'd27,  32'd10241,     16'd0,      1'b0, 14'd0, 6'd0},
      '{OP_GEN,         8'd0,   32'd0,         16'd0,      1'b0, 14'd0, 6'd0},
      '{OP_LOAD_FIRST,  8'd27,  32'd491582,    16'd0,      1'b0, 14'd0, 6'd0},
      '{OP_GEN,         8'd0,   32'd0,         16'd0,      1'b0, 14'd0, 6'd0},
      '{OP_LOAD_FIRST,  8'd27,  32'd712794,    16'd0,      1'b0, 14'd0, 6'd0},
      '{OP_GEN,         8'd0,   32'd0,         16'd0,      1'b0, 14'd0, 6'd0},
      '{OP_LOAD_FIRST,  8'd27,  32'd831695,    16'd0,      1'b0, 14'd0, 6'd0},
      '{OP_GEN,         8'd0,   32'd0,         16'd0,      1'b0, 14'd0, 6'd0},
      // degree 11 and degree 40 wrap past L and skip
      '{OP_LOAD_FIRST,  8'd27,  32'd948446,    16'd0,      1'b0, 14'd0, 6'd0},
      '{OP_GEN,         8'd0,   32'd0,         16'd0,      1'b0, 14'd0, 6'd0},
      '{OP_LOAD_FIRST,  8'd27,  32'd1032189,   16'd0,      1'b0, 14'd0, 6'd0},
      '{OP_GEN,         8'd0,   32'd0,         16'd0,      1'b0, 14'd0, 6'd0},
      // start at 3 for the longest run
      '{OP_LOAD_SECOND, 8'd42,  32'd3,         16'd0,      1'b0, 14'd0, 6'd0},
      '{OP_GEN,         8'd0,   32'd0,         16'd0,      1'b0, 14'd0, 6'd0},
      '{OP_GEN,         8'd0,   32'd0,         16'hFFFF,   1'b0, 14'd0, 6'd0}
    };

    settings = '{
      '{16'd65535, 14'd16383, 14'd16383, 1'b1, 1'b0, 1'b0},
      '{16'd1234,  14'd97,    14'd101,   1'b0, 1'b1, 1'b0},
      '{16'd0,     14'd0,     14'd7,     1'b0, 1'b0, 1'b0},
      '{16'd7,     14'd10,    14'd12,    1'b0, 1'b0, 1'b1},
      '{16'd300,   14'd3,     14'd0,     1'b0, 1'b0, 1'b0},
      '{16'd301,   14'd16383, 14'd1,     1'b0, 1'b0, 1'b0},
      '{16'd4000,  14'd9000,  14'd16381, 1'b0, 1'b1, 1'b0},
      '{16'd40000, 14'd200,   14'd211,   1'b0, 1'b0, 1'b1}
    };

    // reset
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table under the reset register values
    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == OP_GEN && !directed_rows[i].typed)
        ensure_tables(directed_rows[i].sym);
      send_request(directed_rows[i].op, directed_rows[i].tindex, directed_rows[i].word,
                   directed_rows[i].sym);
      if (directed_rows[i].typed) begin
        typed_result = '{directed_rows[i].t_index, directed_rows[i].t_degree, 6'd0, 1'b1};
        pending_indices.push_back(typed_result);
        degrees_seen[directed_rows[i].t_degree] = 1'b1;
      end else begin
        predict_request(directed_rows[i].op, directed_rows[i].tindex, directed_rows[i].word,
                        directed_rows[i].sym);
      end
    end
    run_random(ITEMS_PER_SETTING, 1'b0, 1'b0);

    // random traffic under each register setting
    foreach (settings[p]) begin
      in_tvalid <= 1'b0;
      drain_results();
      no_idle = settings[p].no_idle;
      program_registers(settings[p]);
      run_random(ITEMS_PER_SETTING, settings[p].long_hold, settings[p].mid_pause);
    end

    // final drain and tail
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_indices.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d generate and %0d load requests over %0d register settings",
             gen_requests, load_requests, NUM_SETTINGS + 1);
    $display("%0d indices checked, %0d distinct degrees, %0d runs of degree 40",
             indices_checked, $countones(degrees_seen), deg40_runs);
    if (mismatch_count == 0 && pending_indices.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
